### rtl/core/cfce_pkg.sv
// Shared types and constants for the command frame CRC-16 encoder.
package cfce_pkg;

	localparam int CFG_INDEX_W = 3;

	// Register indexes on the configuration port.
	localparam logic [CFG_INDEX_W-1:0] REG_TARGET_ID      = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_COMMAND_CODE   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_CRC_POLYNOMIAL = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_CRC_INITIAL    = 3'd3;

	localparam logic [15:0] TARGET_ID_RST      = 16'h0000;
	localparam logic [7:0]  COMMAND_CODE_RST   = 8'h00;
	localparam logic [15:0] CRC_POLYNOMIAL_RST = 16'hA001;
	localparam logic [15:0] CRC_INITIAL_RST    = 16'hC181;

	// Byte positions within the part of a frame that one request can produce.
	localparam int NUM_STEPS = 6;
	localparam logic [2:0] STEP_ID_LO  = 3'd0;
	localparam logic [2:0] STEP_ID_HI  = 3'd1;
	localparam logic [2:0] STEP_CMD    = 3'd2;
	localparam logic [2:0] STEP_DATA   = 3'd3;
	localparam logic [2:0] STEP_CRC_LO = 3'd4;
	localparam logic [2:0] STEP_CRC_HI = 3'd5;

	typedef struct packed {
		logic [15:0] target_id;
		logic [7:0]  command_code;
		logic [15:0] crc_polynomial;
		logic [15:0] crc_initial;
	} cfg_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] frame_byte;
		logic       end_of_frame;
	} emit_t;

endpackage

### rtl/core/command_frame_crc16_encoder.sv
// Top level of the command frame encoder with its output register.
//
// Each request carries at most one payload byte and may close the frame. The
// first request of a frame also puts out the target id (low byte first) and
// the command code, and a closing request appends the CRC-16, low byte first,
// with end_of_frame set on its high byte. The CRC is reflected, shifted right,
// starts from crc_initial and covers every earlier byte of the frame. The block
// puts out one frame byte per clock cycle while the output is not stalled, and
// holds a request until it has produced all of its bytes: up to six for a first
// request that also closes the frame, one for a payload byte inside a frame.
// The next request is taken in the cycle that its predecessor hands over
// its last byte to the output register. Configuration writes take effect at once
// and should be made while no frame is open.
module command_frame_crc16_encoder (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [cfce_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [15:0]                      cfg_data,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  logic [7:0]                       payload_byte,
	input  logic                             has_byte,
	input  logic                             is_last,
	output logic                             byte_valid,
	input  logic                             byte_stall,
	output logic [7:0]                       frame_byte,
	output logic                             end_of_frame
);
	import cfce_pkg::*;

	cfg_t  cfg;
	emit_t emit;
	logic  out_ready;
	logic  byte_valid_q;
	logic [7:0] frame_byte_q;
	logic  end_of_frame_q;

	cfce_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg_ready (cfg_ready),
		.cfg       (cfg)
	);

	cfce_sequencer u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.payload_byte (payload_byte),
		.has_byte     (has_byte),
		.is_last      (is_last),
		.out_ready    (out_ready),
		.emit         (emit)
	);

	assign out_ready = !byte_valid_q || !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_q <= 1'b0;
		end else if (out_ready) begin
			byte_valid_q <= emit.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && emit.valid) begin
			frame_byte_q   <= emit.frame_byte;
			end_of_frame_q <= emit.end_of_frame;
		end
	end

	assign byte_valid   = byte_valid_q;
	assign frame_byte   = frame_byte_q;
	assign end_of_frame = end_of_frame_q;

endmodule

### rtl/core/cfce_cfg_regs.sv
// Configuration register file for the command frame encoder.
module cfce_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic [cfce_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [15:0]                      cfg_data,
	output logic                             cfg_ready,
	output cfce_pkg::cfg_t                   cfg
);
	import cfce_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_id      <= TARGET_ID_RST;
			cfg_q.command_code   <= COMMAND_CODE_RST;
			cfg_q.crc_polynomial <= CRC_POLYNOMIAL_RST;
			cfg_q.crc_initial    <= CRC_INITIAL_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TARGET_ID:      cfg_q.target_id      <= cfg_data;
				REG_COMMAND_CODE:   cfg_q.command_code   <= cfg_data[7:0];
				REG_CRC_POLYNOMIAL: cfg_q.crc_polynomial <= cfg_data;
				REG_CRC_INITIAL:    cfg_q.crc_initial    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule

### rtl/core/cfce_crc_byte.sv
// One-byte update of a reflected CRC-16 with a programmable polynomial.
module cfce_crc_byte (
	input  logic [15:0] crc_in,
	input  logic [7:0]  data,
	input  logic [15:0] poly,
	output logic [15:0] crc_out
);

	always_comb begin
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
		end
		crc_out = c;
	end

endmodule

### rtl/core/cfce_sequencer.sv
// Request holding register and byte sequencer with the running CRC.
module cfce_sequencer (
	input  logic              clk,
	input  logic              arst_n,
	input  cfce_pkg::cfg_t    cfg,
	input  logic              item_valid,
	output logic              item_stall,
	input  logic [7:0]        payload_byte,
	input  logic              has_byte,
	input  logic              is_last,
	input  logic              out_ready,
	output cfce_pkg::emit_t   emit
);
	import cfce_pkg::*;

	logic        item_full_q;
	logic [7:0]  payload_q;
	logic        has_q;
	logic        last_q;
	logic [2:0]  pos_q;
	logic        in_frame_q;
	logic [15:0] crc_q;

	logic [NUM_STEPS-1:0] needed;
	logic [2:0]  cur;
	logic        found;
	logic        more;
	logic        fire;
	logic        item_done;
	logic [7:0]  cur_byte;
	logic [15:0] crc_base;
	logic [15:0] crc_next;

	// Header bytes are needed only while no frame is open.
	assign needed = {last_q, last_q, has_q, ~in_frame_q, ~in_frame_q, ~in_frame_q};

	// Pick the first needed position at or after pos_q, and see whether more follow.
	always_comb begin
		found = 1'b0;
		more  = 1'b0;
		cur   = STEP_ID_LO;
		for (int i = 0; i < NUM_STEPS; i++) begin
			if (needed[i] && (3'(i) >= pos_q)) begin
				if (found) begin
					more = 1'b1;
				end else begin
					found = 1'b1;
					cur   = 3'(i);
				end
			end
		end
	end

	always_comb begin
		case (cur)
			STEP_ID_LO:  cur_byte = cfg.target_id[7:0];
			STEP_ID_HI:  cur_byte = cfg.target_id[15:8];
			STEP_CMD:    cur_byte = cfg.command_code;
			STEP_DATA:   cur_byte = payload_q;
			STEP_CRC_LO: cur_byte = crc_q[7:0];
			STEP_CRC_HI: cur_byte = crc_q[15:8];
			default:     cur_byte = 8'h00;
		endcase
	end

	assign crc_base = (cur == STEP_ID_LO) ? cfg.crc_initial : crc_q;

	cfce_crc_byte u_crc (
		.crc_in  (crc_base),
		.data    (cur_byte),
		.poly    (cfg.crc_polynomial),
		.crc_out (crc_next)
	);

	assign fire      = item_full_q && found && out_ready;
	assign item_done = item_full_q && (!found || (out_ready && !more));
	assign item_stall = item_full_q && !item_done;

	assign emit.valid        = fire;
	assign emit.frame_byte   = cur_byte;
	assign emit.end_of_frame = (cur == STEP_CRC_HI);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_full_q <= 1'b0;
			pos_q       <= STEP_ID_LO;
			in_frame_q  <= 1'b0;
		end else begin
			if (item_valid && !item_stall) begin
				item_full_q <= 1'b1;
			end else if (item_done) begin
				item_full_q <= 1'b0;
			end
			if (item_done) begin
				pos_q <= STEP_ID_LO;
			end else if (fire) begin
				pos_q <= cur + 3'd1;
			end
			if (fire && cur == STEP_CMD) begin
				in_frame_q <= 1'b1;
			end else if (fire && cur == STEP_CRC_HI) begin
				in_frame_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			payload_q <= payload_byte;
			has_q     <= has_byte;
			last_q    <= is_last;
		end
		if (fire && cur <= STEP_DATA) begin
			crc_q <= crc_next;
		end
	end

endmodule

### rtl/core/cfce_checker.sv
// Port-level checker for the command frame encoder and its bind.
module cfce_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_valid,
	input logic       cfg_ready,
	input logic       item_stall,
	input logic       byte_valid,
	input logic       byte_stall,
	input logic [7:0] frame_byte,
	input logic       end_of_frame
);

	// Bytes delivered in the current frame, saturating once the minimum is reached.
	logic [2:0] count_q;
	logic       out_take;

	assign out_take = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 3'd0;
		end else if (out_take) begin
			if (end_of_frame) begin
				count_q <= 3'd0;
			end else if (count_q != 3'd4) begin
				count_q <= count_q + 3'd1;
			end
		end
	end

	// A frame holds at least the three header bytes and the CRC low byte ahead of its end.
	a_frame_length: assert property (@(posedge clk) disable iff (!arst_n)
		out_take && end_of_frame |-> count_q == 3'd4)
		else $error("frame closed with fewer than five bytes");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_stall |=> byte_valid && $stable(frame_byte)
			&& $stable(end_of_frame))
		else $error("stalled frame byte changed or was dropped");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write was not taken");

	// A request that is held while the output register is empty must put a byte into it.
	a_progress: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall && !byte_valid |=> byte_valid)
		else $error("held request made no progress");

endmodule

bind command_frame_crc16_encoder cfce_checker u_cfce_checker (.*);
